### sv/srag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srag_pkg
// Shared types and constants of the strided row address generator.
// ----------------------------------------------------------------------------
package srag_pkg;

    localparam int MAX_OUTER_DIMS = 4;
    localparam int DIM_SEL_W      = (MAX_OUTER_DIMS > 1) ? $clog2(MAX_OUTER_DIMS) : 1;
    localparam int CNT_W          = $clog2(MAX_OUTER_DIMS + 1);

    localparam int OFFSET_W = 48;
    localparam int COPY_W   = 20;
    localparam int DIVD_W   = 32;
    localparam int DIVS_W   = 16;

    localparam logic [COPY_W-1:0] COPY_MAX = {COPY_W{1'b1}};

    localparam logic CMD_SET       = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    typedef enum logic [1:0] {
        CFG_OUTER_DIMS    = 2'd0,
        CFG_ROW_ELEMENTS  = 2'd1,
        CFG_ELEMENT_BYTES = 2'd2,
        CFG_ROW_COUNT     = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_WAIT,
        ST_MAC_DST,
        ST_MAC_SRC,
        ST_SCALE_DST,
        ST_SCALE_SRC,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MAC_HOLD,
        MAC_CLEAR,
        MAC_ACC_DST,
        MAC_ACC_SRC,
        MAC_SCALE_DST,
        MAC_SCALE_SRC
    } mac_op_t;

    typedef struct packed {
        mac_op_t            op;
        logic [31:0]        digit;
        logic signed [31:0] stride;
        logic [4:0]         scale;
    } mac_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } div_result_t;

    typedef struct packed {
        logic               command;
        logic [1:0]         dim_index;
        logic [15:0]        extent;
        logic signed [31:0] dst_stride;
        logic signed [31:0] src_stride;
        logic [31:0]        row_index;
    } in_req_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] dst_byte_offset;
        logic signed [OFFSET_W-1:0] src_byte_offset;
        logic [COPY_W-1:0]          copy_bytes;
        logic                       row_out_of_range;
    } out_rsp_t;

endpackage
`default_nettype wire

### sv/srag_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srag_divider
// Restoring divider, one quotient bit per cycle, unsigned 32 by 16 bits.
// ----------------------------------------------------------------------------
module srag_divider
    import srag_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output div_result_t            result
);

    localparam int STEP_W = $clog2(DIVD_W);

    logic [DIVD_W-1:0] q_reg, q_next;
    logic [DIVS_W-1:0] r_reg, r_next;
    logic [DIVS_W-1:0] d_reg, d_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    always_comb begin
        trial     = {r_reg, q_reg[DIVD_W-1]};
        diff      = trial - {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIVS_W]) begin
                r_next = diff[DIVS_W-1:0];
                q_next = {q_reg[DIVD_W-2:0], 1'b1};
            end else begin
                r_next = trial[DIVS_W-1:0];
                q_next = {q_reg[DIVD_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = q_reg;
    assign result.remainder = r_reg;

endmodule
`default_nettype wire

### sv/srag_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srag_mac
// Offset accumulators: digit times stride, then scale by element size.
// ----------------------------------------------------------------------------
module srag_mac
    import srag_pkg::*;
(
    input  wire logic                  aclk,
    input  wire mac_ctrl_t             ctrl,
    output logic signed [OFFSET_W-1:0] dst_acc,
    output logic signed [OFFSET_W-1:0] src_acc
);

    logic [OFFSET_W-1:0]   dst_reg, dst_next;
    logic [OFFSET_W-1:0]   src_reg, src_next;
    logic signed [32:0]    mul_a;
    logic signed [64:0]    mul_p;
    logic [OFFSET_W-1:0]   scale_in;
    logic [OFFSET_W+4:0]   scale_p;

    always_comb begin
        mul_a    = $signed({1'b0, ctrl.digit});
        mul_p    = mul_a * ctrl.stride;
        scale_in = (ctrl.op == MAC_SCALE_SRC) ? src_reg : dst_reg;
        scale_p  = scale_in * ctrl.scale;
        dst_next = dst_reg;
        src_next = src_reg;
        case (ctrl.op)
            MAC_CLEAR: begin
                dst_next = '0;
                src_next = '0;
            end
            MAC_ACC_DST:   dst_next = dst_reg + mul_p[OFFSET_W-1:0];
            MAC_ACC_SRC:   src_next = src_reg + mul_p[OFFSET_W-1:0];
            MAC_SCALE_DST: dst_next = scale_p[OFFSET_W-1:0];
            MAC_SCALE_SRC: src_next = scale_p[OFFSET_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        dst_reg <= dst_next;
        src_reg <= src_next;
    end

    assign dst_acc = $signed(dst_reg);
    assign src_acc = $signed(src_reg);

endmodule
`default_nettype wire

### sv/strided_row_address_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strided_row_address_generator
// Splits a flat row index into mixed-radix digits over the outer dimensions
// and returns source and destination byte offsets of that row.
//
//   channel  ports               direction  content
//   cfg      cfg_wr_*            in         register writes
//   s        s_valid/s_ready     in         set-dimension or translate request
//   m        m_valid/m_ready     out        offsets, copy length, range flag
//
// A set request gives no result. A translate request runs the one-bit-per-cycle
// divider once per outer dimension in use (up to four); a dimension with a
// zero extent takes the whole rest as its digit and skips the divider. Reset
// is synchronous, active low. A request is taken while a result waits; a
// finished result waits for the output register.
// ----------------------------------------------------------------------------
module strided_row_address_generator
    import srag_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_req_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_rsp_t         m_data
);

    logic [2:0]  outer_dims_reg;
    logic [15:0] row_elements_reg;
    logic [4:0]  element_bytes_reg;
    logic [31:0] row_count_reg;

    logic [15:0]        extent_tab   [MAX_OUTER_DIMS];
    logic signed [31:0] dst_str_tab  [MAX_OUTER_DIMS];
    logic signed [31:0] src_str_tab  [MAX_OUTER_DIMS];

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       digit_reg, digit_next;
    logic [31:0]       row_reg, row_next;
    logic              m_valid_reg, m_valid_next;
    out_rsp_t          m_data_reg, m_data_next;

    logic              s_fire;
    logic              set_fire;
    logic [CNT_W-1:0]  dims;
    logic [CNT_W-1:0]  cnt_m1;
    logic [DIM_SEL_W-1:0] idx;
    logic [20:0]       copy_raw;
    logic              div_start;
    div_result_t       div_res;
    mac_ctrl_t         mac_ctrl;
    logic signed [OFFSET_W-1:0] dst_acc;
    logic signed [OFFSET_W-1:0] src_acc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign set_fire = s_fire && (s_data.command == CMD_SET)
                      && ({30'd0, s_data.dim_index} < 32'(MAX_OUTER_DIMS));
    assign dims     = ({29'd0, outer_dims_reg} > 32'(MAX_OUTER_DIMS))
                      ? CNT_W'(MAX_OUTER_DIMS) : CNT_W'(outer_dims_reg);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign idx      = cnt_m1[DIM_SEL_W-1:0];
    assign copy_raw = row_elements_reg * element_bytes_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_dims_reg    <= 3'd1;
            row_elements_reg  <= 16'd1;
            element_bytes_reg <= 5'd1;
            row_count_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                CFG_OUTER_DIMS:    outer_dims_reg    <= cfg_wr_data[2:0];
                CFG_ROW_ELEMENTS:  row_elements_reg  <= cfg_wr_data[15:0];
                CFG_ELEMENT_BYTES: element_bytes_reg <= cfg_wr_data[4:0];
                CFG_ROW_COUNT:     row_count_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // dimension tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < MAX_OUTER_DIMS; d++) begin
                extent_tab[d]  <= '1;
                dst_str_tab[d] <= '0;
                src_str_tab[d] <= '0;
            end
        end else if (set_fire) begin
            extent_tab[s_data.dim_index[DIM_SEL_W-1:0]]  <= s_data.extent;
            dst_str_tab[s_data.dim_index[DIM_SEL_W-1:0]] <= s_data.dst_stride;
            src_str_tab[s_data.dim_index[DIM_SEL_W-1:0]] <= s_data.src_stride;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        digit_next   = digit_reg;
        row_next     = row_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        mac_ctrl.op     = MAC_HOLD;
        mac_ctrl.digit  = digit_reg;
        mac_ctrl.stride = dst_str_tab[idx];
        mac_ctrl.scale  = element_bytes_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.command == CMD_TRANSLATE)) begin
                    row_next    = s_data.row_index;
                    rem_next    = s_data.row_index;
                    cnt_next    = dims;
                    mac_ctrl.op = MAC_CLEAR;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (cnt_reg == '0) begin
                    state_next = ST_SCALE_DST;
                end else if (extent_tab[idx] == '0) begin
                    digit_next = rem_reg;
                    rem_next   = '0;
                    state_next = ST_MAC_DST;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    digit_next = {16'd0, div_res.remainder};
                    rem_next   = div_res.quotient;
                    state_next = ST_MAC_DST;
                end
            end
            ST_MAC_DST: begin
                mac_ctrl.op = MAC_ACC_DST;
                state_next  = ST_MAC_SRC;
            end
            ST_MAC_SRC: begin
                mac_ctrl.op     = MAC_ACC_SRC;
                mac_ctrl.stride = src_str_tab[idx];
                cnt_next        = cnt_m1;
                state_next      = ST_CHECK;
            end
            ST_SCALE_DST: begin
                mac_ctrl.op = MAC_SCALE_DST;
                state_next  = ST_SCALE_SRC;
            end
            ST_SCALE_SRC: begin
                mac_ctrl.op = MAC_SCALE_SRC;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.dst_byte_offset = dst_acc;
                    m_data_next.src_byte_offset = src_acc;
                    m_data_next.copy_bytes      = copy_raw[20] ? COPY_MAX
                                                  : copy_raw[COPY_W-1:0];
                    m_data_next.row_out_of_range = (row_reg >= row_count_reg);
                    state_next                  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        rem_reg    <= rem_next;
        digit_reg  <= digit_next;
        row_reg    <= row_next;
        m_data_reg <= m_data_next;
    end

    srag_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (extent_tab[idx]),
        .result   (div_res)
    );

    srag_mac u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .dst_acc (dst_acc),
        .src_acc (src_acc)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

### tb/sv/row_offset_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_offset_checker
// Watches the register port and the request and result channels of the strided row
// address generator. Keeps its own copy of the registers and the dimension
// tables, predicts the offsets, copy length and range flag of each translate
// request, and compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module row_offset_checker
    import srag_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_req_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_rsp_t    m_data,
    output int unsigned mismatch_count,
    output int unsigned outstanding
);

    logic [2:0]  outer_dims;
    logic [15:0] row_elements;
    logic [4:0]  element_bytes;
    logic [31:0] row_count;
    logic [15:0] extents     [MAX_OUTER_DIMS];
    logic [31:0] dst_strides [MAX_OUTER_DIMS];
    logic [31:0] src_strides [MAX_OUTER_DIMS];

    out_rsp_t    expected_rows [$];
    out_rsp_t    want;
    int unsigned errors = 0;
    int unsigned results = 0;

    assign mismatch_count = errors;

    function automatic out_rsp_t translate_row(input logic [31:0] row);
        out_rsp_t    rsp;
        logic [63:0] dst_acc;
        logic [63:0] src_acc;
        logic [63:0] dst_scaled;
        logic [63:0] src_scaled;
        logic [31:0] rest;
        logic [31:0] digit;
        logic [20:0] copy_len;
        int          dims;
        dst_acc = '0;
        src_acc = '0;
        rest    = row;
        dims    = (outer_dims > MAX_OUTER_DIMS) ? MAX_OUTER_DIMS : int'(outer_dims);
        // innermost outer dimension first, zero extent takes the whole rest
        for (int j = dims - 1; j >= 0; j--) begin
            if (extents[j] == '0) begin
                digit = rest;
                rest  = '0;
            end else begin
                digit = rest % 32'(extents[j]);
                rest  = rest / 32'(extents[j]);
            end
            dst_acc += 64'(digit) * {{32{dst_strides[j][31]}}, dst_strides[j]};
            src_acc += 64'(digit) * {{32{src_strides[j][31]}}, src_strides[j]};
        end
        dst_scaled = dst_acc * 64'(element_bytes);
        src_scaled = src_acc * 64'(element_bytes);
        copy_len   = 21'(row_elements) * 21'(element_bytes);
        rsp.dst_byte_offset  = dst_scaled[OFFSET_W-1:0];
        rsp.src_byte_offset  = src_scaled[OFFSET_W-1:0];
        rsp.copy_bytes       = (copy_len > 21'(COPY_MAX)) ? COPY_MAX : copy_len[COPY_W-1:0];
        rsp.row_out_of_range = (row >= row_count);
        return rsp;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            outer_dims    <= 3'd1;
            row_elements  <= 16'd1;
            element_bytes <= 5'd1;
            row_count     <= '0;
            for (int d = 0; d < MAX_OUTER_DIMS; d++) begin
                extents[d]     <= '1;
                dst_strides[d] <= '0;
                src_strides[d] <= '0;
            end
            expected_rows.delete();
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_OUTER_DIMS:    outer_dims    <= cfg_wr_data[2:0];
                    CFG_ROW_ELEMENTS:  row_elements  <= cfg_wr_data[15:0];
                    CFG_ELEMENT_BYTES: element_bytes <= cfg_wr_data[4:0];
                    default:           row_count     <= cfg_wr_data;
                endcase
            end
            // compare before taking a new request so a result never pairs with it
            if (m_valid && m_ready) begin
                results++;
                if (expected_rows.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d with no request waiting: dst %0h src %0h copy %0h oor %0b",
                                 results, m_data.dst_byte_offset, m_data.src_byte_offset,
                                 m_data.copy_bytes, m_data.row_out_of_range);
                end else begin
                    want = expected_rows.pop_front();
                    if (m_data.dst_byte_offset !== want.dst_byte_offset ||
                        m_data.src_byte_offset !== want.src_byte_offset ||
                        m_data.copy_bytes !== want.copy_bytes ||
                        m_data.row_out_of_range !== want.row_out_of_range) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d: expected dst %0h src %0h copy %0h oor %0b, got dst %0h src %0h copy %0h oor %0b",
                                     results, want.dst_byte_offset, want.src_byte_offset,
                                     want.copy_bytes, want.row_out_of_range,
                                     m_data.dst_byte_offset, m_data.src_byte_offset,
                                     m_data.copy_bytes, m_data.row_out_of_range);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_TRANSLATE) begin
                    expected_rows.push_back(translate_row(s_data.row_index));
                end else if (s_data.dim_index < MAX_OUTER_DIMS) begin
                    extents[s_data.dim_index]     <= s_data.extent;
                    dst_strides[s_data.dim_index] <= s_data.dst_stride;
                    src_strides[s_data.dim_index] <= s_data.src_stride;
                end
            end
            outstanding <= expected_rows.size();
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the strided row address generator with directed and random
// set-dimension and translate requests over several register settings,
// with random gaps and long stalls on both channels, and reports the verdict
// from the failure count of the row offset checker.
// ----------------------------------------------------------------------------
module testbench;
    import srag_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int STALL_LONG     = 800;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 98;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_req_t     s_data;
    logic        m_valid;
    logic        m_ready;
    out_rsp_t    m_data;
    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned sent = 0;
    int unsigned quiet_cycles = 0;

    always #5 aclk = ~aclk;

    strided_row_address_generator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    row_offset_checker offset_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    function automatic in_req_t random_req();
        in_req_t r;
        r.command    = 1'($urandom());
        r.dim_index  = 2'($urandom());
        r.extent     = 16'($urandom());
        r.dst_stride = $urandom();
        r.src_stride = $urandom();
        r.row_index  = $urandom();
        return r;
    endfunction

    function automatic logic [15:0] pick_extent();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return 16'($urandom_range(12, 1));
        if (roll < 80) return 16'd0;
        if (roll < 90) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    function automatic logic [31:0] pick_stride();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return $urandom_range(128) - 32'd64;
        if (roll < 80) begin
            case ($urandom_range(4))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                3: return 32'd0;
                default: return 32'd1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_row(input logic [31:0] rc);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return (rc == 0) ? $urandom() : $urandom_range(rc - 1, 0);
        if (roll < 80) begin
            case ($urandom_range(3))
                0: return 32'd0;
                1: return rc - 1;
                2: return rc;
                default: return rc + 1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_req(input in_req_t r);
        while (!(sent >= 400 && sent < 520) && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send_set(input int unsigned dim, input logic [15:0] ext,
                            input logic [31:0] dst, input logic [31:0] src);
        in_req_t r;
        r            = random_req();
        r.command    = CMD_SET;
        r.dim_index  = 2'(dim);
        r.extent     = ext;
        r.dst_stride = dst;
        r.src_stride = src;
        send_req(r);
    endtask

    task automatic send_xlate(input logic [31:0] row);
        in_req_t r;
        r           = random_req();
        r.command   = CMD_TRANSLATE;
        r.row_index = row;
        send_req(r);
    endtask

    // drop valid, wait for every result, then let a set in flight finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(input logic [31:0] od, input logic [31:0] re,
                               input logic [31:0] eb, input logic [31:0] rc);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_OUTER_DIMS;
        cfg_wr_data  <= od;
        @(posedge aclk);
        cfg_wr_index <= CFG_ROW_ELEMENTS;
        cfg_wr_data  <= re;
        @(posedge aclk);
        cfg_wr_index <= CFG_ELEMENT_BYTES;
        cfg_wr_data  <= eb;
        @(posedge aclk);
        cfg_wr_index <= CFG_ROW_COUNT;
        cfg_wr_data  <= rc;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // result side: random stalls, two long hold-offs, one calm stretch
    initial begin
        int unsigned taken;
        taken = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            m_ready <= (taken >= 250 && taken < 330) || ($urandom_range(99) >= 27);
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken++;
                if (taken == 120 || taken == 360) begin
                    m_ready <= 1'b0;
                    repeat (STALL_LONG) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [31:0] od;
        logic [31:0] re;
        logic [31:0] eb;
        logic [31:0] rc;
        logic [63:0] rows_total;
        logic [15:0] ext_plan [MAX_OUTER_DIMS];
        int unsigned dims;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= CFG_OUTER_DIMS;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_xlate(32'd0);
        send_xlate(32'hFFFF_FFFF);
        settle();

        load_config(32'd4, 32'd65535, 32'd16, 32'hFFFF_FFFF);
        send_set(0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_set(1, 16'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_set(2, 16'd0, 32'hFFFF_FFFF, 32'd1);
        send_set(3, 16'd7, 32'd3, 32'hFFFF_FFFD);
        send_xlate(32'd0);
        send_xlate(32'hFFFF_FFFF);
        send_xlate(32'hFFFF_FFFE);
        send_xlate(32'd12345);
        send_set(3, 16'd0, 32'd1, 32'hFFFF_FFFF);
        send_xlate(32'hDEAD_BEEF);
        settle();

        load_config(32'd0, 32'd65535, 32'd31, 32'd5);
        send_xlate(32'd5);
        send_xlate(32'd4);
        settle();

        load_config(32'd7, 32'd0, 32'd0, 32'd1);
        send_xlate(32'd0);
        send_xlate(32'd1);
        send_xlate(32'h89AB_CDEF);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: od = 32'd4;
                1: od = 32'd1;
                2: od = 32'd0;
                3: od = 32'd7;
                default: od = ($urandom_range(99) < 80) ? $urandom_range(4, 1)
                                                        : $urandom_range(7, 0);
            endcase
            case (p)
                0: re = 32'd65535;
                1: re = 32'd1;
                2: re = 32'd0;
                default: re = ($urandom_range(99) < 30) ? $urandom_range(16, 1)
                                                        : 32'($urandom_range(65535));
            endcase
            case (p)
                0: eb = 32'd16;
                1: eb = 32'd1;
                4: eb = 32'd31;
                5: eb = 32'd0;
                default: eb = ($urandom_range(99) < 80) ? $urandom_range(16, 1)
                                                        : $urandom_range(31, 0);
            endcase
            for (int d = 0; d < MAX_OUTER_DIMS; d++)
                ext_plan[d] = pick_extent();
            dims       = (od[2:0] > MAX_OUTER_DIMS) ? MAX_OUTER_DIMS : od[2:0];
            rows_total = 64'd1;
            for (int d = 0; d < int'(dims); d++)
                rows_total = rows_total * 64'(ext_plan[d]);
            case (p)
                0: rc = 32'hFFFF_FFFF;
                1: rc = 32'd0;
                7: rc = $urandom();
                default: rc = rows_total[31:0];
            endcase
            // unused upper bits of the write data must be dropped
            if (p >= 6) begin
                od = od | ($urandom() << 3);
                re = re | ($urandom() << 16);
                eb = eb | ($urandom() << 5);
            end
            load_config(od, re, eb, rc);

            for (int d = 0; d < MAX_OUTER_DIMS; d++)
                send_set(d, ext_plan[d], pick_stride(), pick_stride());
            for (int n = 0; n < PHASE_ITEMS - MAX_OUTER_DIMS; n++) begin
                if (p == 5 && n == 40)
                    settle();
                if ($urandom_range(99) < 8)
                    send_set($urandom_range(3, 0), pick_extent(), pick_stride(), pick_stride());
                else
                    send_xlate(pick_row(rc));
            end
            settle();
        end

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
